>>> rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// Multitouch contact tracker package
// Shared widths, defaults and the structures that pass between the
// sequencer, the compare unit and the event output stage.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int MAX_SLOTS_DEF = 8;
    localparam int CFG_W         = 4;
    localparam int ID_W          = 16;
    localparam int POS_W         = 16;
    localparam int STAMP_W       = 32;
    localparam int ID_LOW_W      = 8;
    localparam int CNT_OUT_W     = 4;

    localparam logic [CFG_W-1:0] MAX_POINTS_RST = 4'd8;

    typedef struct packed {
        logic        [ID_W-1:0]  id_a;
        logic        [ID_W-1:0]  id_b;
        logic signed [POS_W-1:0] x_a;
        logic signed [POS_W-1:0] x_b;
        logic signed [POS_W-1:0] y_a;
        logic signed [POS_W-1:0] y_b;
    } t_cmp_req;

    typedef struct packed {
        logic id_eq;
        logic pos_ne;
    } t_cmp_rsp;

    typedef struct packed {
        logic signed [POS_W-1:0]     x;
        logic signed [POS_W-1:0]     y;
        logic                        pressed;
        logic        [ID_LOW_W-1:0]  id;
        logic        [STAMP_W-1:0]   stamp;
        logic        [CNT_OUT_W-1:0] count;
    } t_event;

endpackage

>>> rtl/multitouch_contact_tracker_unit.sv
// ----------------------------------------------------------------------------
// Multitouch contact tracker
// Collects one frame of touch samples and, at frame end, emits pressed and
// released events against the contacts held from the previous frame.
//
// A request is taken at a rising edge with i_start high and o_busy low.
// A request without i_frame_end only stores its sample (if any and if the
// frame is below the max_points limit); o_busy stays low. A request with
// i_frame_end raises o_busy while one shared compare unit walks the tables,
// one pair per cycle. Each event appears on the o_ev_* ports for one cycle
// with o_strobe; o_last marks the frame's final event, which leaves in the
// same cycle that o_busy falls. The receiver cannot stall.
// i_cfg_we writes max_points; the user must write it only while the block
// is idle, since the block itself does not enforce this.
// Reset clears the contact and sample counts and sets max_points to 8.
// ----------------------------------------------------------------------------
module multitouch_contact_tracker_unit
    import mct_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_has_touch,
    input  logic        [ID_W-1:0]     i_touch_id,
    input  logic signed [POS_W-1:0]    i_pos_x,
    input  logic signed [POS_W-1:0]    i_pos_y,
    input  logic                       i_frame_end,
    input  logic        [STAMP_W-1:0]  i_stamp,
    input  logic                       i_cfg_we,
    input  logic        [CFG_W-1:0]    i_cfg_wdata,
    output logic                       o_strobe,
    output logic signed [POS_W-1:0]    o_ev_x,
    output logic signed [POS_W-1:0]    o_ev_y,
    output logic                       o_pressed,
    output logic        [ID_LOW_W-1:0] o_ev_id,
    output logic        [STAMP_W-1:0]  o_ev_stamp,
    output logic        [CNT_OUT_W-1:0] o_active_count,
    output logic                       o_last
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SURV  = 6'b000010,
        S_NEWID = 6'b000100,
        S_PRESS = 6'b001000,
        S_REL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_max;
    logic [CW-1:0]    r_prev_cnt, r_frame_cnt;
    logic [CW-1:0]    r_n, n_n, r_i, n_i, r_j, n_j;
    logic             r_changed, n_changed;
    logic [STAMP_W-1:0] r_stamp;

    logic        [ID_W-1:0]  r_prev_id  [MAX_SLOTS];
    logic signed [POS_W-1:0] r_prev_x   [MAX_SLOTS];
    logic signed [POS_W-1:0] r_prev_y   [MAX_SLOTS];
    logic        [ID_W-1:0]  r_frame_id [MAX_SLOTS];
    logic signed [POS_W-1:0] r_frame_x  [MAX_SLOTS];
    logic signed [POS_W-1:0] r_frame_y  [MAX_SLOTS];
    logic        [ID_W-1:0]  r_new_id   [MAX_SLOTS];
    logic signed [POS_W-1:0] r_new_x    [MAX_SLOTS];
    logic signed [POS_W-1:0] r_new_y    [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]    r_dirty;
    logic [MAX_SLOTS-1:0]    r_vanish;

    logic [IW-1:0] w_ii, w_jj, w_nn, w_fc;
    logic [LW-1:0] w_limit;
    logic          w_accept, w_sample;
    t_cmp_req      w_req;
    t_cmp_rsp      w_rsp;
    logic          w_new_wr, w_new_dirty, w_van_set, w_van_clr;
    logic          w_push, w_flush, w_done;
    t_event        w_ev, w_out_ev;

    assign w_ii = r_i[IW-1:0];
    assign w_jj = r_j[IW-1:0];
    assign w_nn = r_n[IW-1:0];
    assign w_fc = r_frame_cnt[IW-1:0];

    assign w_limit  = (LW'(r_cfg_max) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(r_cfg_max);
    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_sample = w_accept && i_has_touch && (LW'(r_frame_cnt) < w_limit);

    always_comb begin
        w_req.id_a = (r_state == S_NEWID) ? r_new_id[w_ii] : r_prev_id[w_ii];
        w_req.id_b = r_frame_id[w_jj];
        w_req.x_a  = r_prev_x[w_ii];
        w_req.x_b  = r_frame_x[w_jj];
        w_req.y_a  = r_prev_y[w_ii];
        w_req.y_b  = r_frame_y[w_jj];
    end

    mct_cmp u_cmp (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_changed   = r_changed;
        w_new_wr    = 1'b0;
        w_new_dirty = 1'b1;
        w_van_set   = 1'b0;
        w_van_clr   = 1'b0;
        w_push      = 1'b0;
        w_flush     = 1'b0;
        w_done      = 1'b0;
        w_ev.x       = r_new_x[w_ii];
        w_ev.y       = r_new_y[w_ii];
        w_ev.pressed = 1'b1;
        w_ev.id      = r_new_id[w_ii][ID_LOW_W-1:0];
        w_ev.stamp   = r_stamp;
        w_ev.count   = CNT_OUT_W'(r_n);
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_frame_end) begin
                    n_state = S_SURV;
                    n_i     = '0;
                    n_j     = '0;
                    n_n     = '0;
                end
            end
            S_SURV: begin
                if (r_i == r_prev_cnt) begin
                    n_state = S_NEWID;
                    n_i     = '0;
                    n_j     = '0;
                end else if (r_j == r_frame_cnt) begin
                    w_van_set = 1'b1;
                    n_i       = r_i + 1'b1;
                    n_j       = '0;
                end else if (w_rsp.id_eq) begin
                    w_new_wr    = 1'b1;
                    w_new_dirty = w_rsp.pos_ne;
                    w_van_clr   = 1'b1;
                    n_n         = r_n + 1'b1;
                    n_i         = r_i + 1'b1;
                    n_j         = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_NEWID: begin
                if (r_j == r_frame_cnt) begin
                    n_state   = S_PRESS;
                    n_i       = '0;
                    n_changed = (r_n != r_prev_cnt);
                end else if (r_i == r_n) begin
                    w_new_wr = 1'b1;
                    n_n      = r_n + 1'b1;
                    n_j      = r_j + 1'b1;
                    n_i      = '0;
                end else if (w_rsp.id_eq) begin
                    n_j = r_j + 1'b1;
                    n_i = '0;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_PRESS: begin
                if (r_i == r_n) begin
                    n_state = S_REL;
                    n_j     = '0;
                end else begin
                    w_push = r_changed || r_dirty[w_ii];
                    n_i    = r_i + 1'b1;
                end
            end
            S_REL: begin
                w_ev.x       = r_prev_x[w_jj];
                w_ev.y       = r_prev_y[w_jj];
                w_ev.pressed = 1'b0;
                w_ev.id      = r_prev_id[w_jj][ID_LOW_W-1:0];
                if (r_j == r_prev_cnt) begin
                    n_state = S_DONE;
                end else begin
                    w_push = r_vanish[w_jj];
                    n_j    = r_j + 1'b1;
                end
            end
            S_DONE: begin
                w_flush = 1'b1;
                w_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_max   <= MAX_POINTS_RST;
            r_prev_cnt  <= '0;
            r_frame_cnt <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_changed   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_n       <= n_n;
            r_i       <= n_i;
            r_j       <= n_j;
            r_changed <= n_changed;
            if (i_cfg_we) begin
                r_cfg_max <= i_cfg_wdata;
            end
            if (w_done) begin
                r_frame_cnt <= '0;
                r_prev_cnt  <= r_n;
            end else if (w_sample) begin
                r_frame_cnt <= r_frame_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_frame_end) begin
            r_stamp <= i_stamp;
        end
        if (w_sample) begin
            r_frame_id[w_fc] <= i_touch_id;
            r_frame_x[w_fc]  <= i_pos_x;
            r_frame_y[w_fc]  <= i_pos_y;
        end
        if (w_new_wr) begin
            r_new_id[w_nn] <= r_frame_id[w_jj];
            r_new_x[w_nn]  <= r_frame_x[w_jj];
            r_new_y[w_nn]  <= r_frame_y[w_jj];
            r_dirty[w_nn]  <= w_new_dirty;
        end
        if (w_van_set) begin
            r_vanish[w_ii] <= 1'b1;
        end else if (w_van_clr) begin
            r_vanish[w_ii] <= 1'b0;
        end
        if (w_done) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_prev_id[k] <= r_new_id[k];
                r_prev_x[k]  <= r_new_x[k];
                r_prev_y[k]  <= r_new_y[k];
            end
        end
    end

    mct_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_ev     (w_ev),
        .i_flush  (w_flush),
        .o_strobe (o_strobe),
        .o_ev     (w_out_ev),
        .o_last   (o_last)
    );

    assign o_ev_x         = w_out_ev.x;
    assign o_ev_y         = w_out_ev.y;
    assign o_pressed      = w_out_ev.pressed;
    assign o_ev_id        = w_out_ev.id;
    assign o_ev_stamp     = w_out_ev.stamp;
    assign o_active_count = w_out_ev.count;

    a_frame_end_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_end) |=> (r_state == S_SURV))
        else $error("frame end request did not start the table walk");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> ((r_state == S_IDLE) && (r_frame_cnt == '0)))
        else $error("frame not closed after the event pass");

    a_new_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n <= CW'(MAX_SLOTS)) && (r_frame_cnt <= CW'(MAX_SLOTS)))
        else $error("contact count beyond slot capacity");

endmodule

>>> rtl/mct_cmp.sv
// ----------------------------------------------------------------------------
// Contact compare unit
// Compares one pair of contact ids and the two positions that go with them.
// The sequencer time-shares it over every pair it has to test.
// ----------------------------------------------------------------------------
module mct_cmp
    import mct_pkg::*;
(
    input  t_cmp_req i_req,
    output t_cmp_rsp o_rsp
);

    assign o_rsp.id_eq  = (i_req.id_a == i_req.id_b);
    assign o_rsp.pos_ne = (i_req.x_a != i_req.x_b) || (i_req.y_a != i_req.y_b);

endmodule

>>> rtl/mct_evq.sv
// ----------------------------------------------------------------------------
// Event output stage
// Holds the newest event back by one so that the final event of a frame
// can be marked, and drives the registered result ports.
// ----------------------------------------------------------------------------
module mct_evq
    import mct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_ev,
    input  logic   i_flush,
    output logic   o_strobe,
    output t_event o_ev,
    output logic   o_last
);

    logic   r_hold_vld;
    t_event r_hold;
    logic   r_out_vld;
    t_event r_out_ev;
    logic   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= (i_push || i_flush) && r_hold_vld;
            if (i_push) begin
                r_hold_vld <= 1'b1;
            end else if (i_flush) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push || i_flush) begin
            r_out_ev   <= r_hold;
            r_out_last <= i_flush;
        end
        if (i_push) begin
            r_hold <= i_ev;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_ev     = r_out_ev;
    assign o_last   = r_out_last;

    a_push_flush_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !i_flush)
        else $error("event push and flush in the same cycle");

    a_flush_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_flush && r_hold_vld) |=> (o_strobe && o_last))
        else $error("held event not released as last on flush");

    a_strobe_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_hold_vld))
        else $error("event strobe without a held event");

endmodule
